// ----- hdl/psi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psi_pkg: shared types, constants and functions
// Item formats, count widths and residue classification for the
// pairwise sequence identity block.
// ----------------------------------------------------------------------------
package psi_pkg;

   localparam int MAX_COLUMNS    = 4096;
   localparam int COUNT_WIDTH    = $clog2(MAX_COLUMNS + 1);
   localparam int IDENTITY_WIDTH = 17;
   localparam int FRACTION_BITS  = 16;
   localparam int PRODUCT_WIDTH  = IDENTITY_WIDTH + COUNT_WIDTH;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic [7:0] residue_query;
      logic [7:0] residue_reference;
      logic       last_column;
   } req_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] identical_count;
      logic [COUNT_WIDTH-1:0] aligned_count;
      logic                   keep_flag;
      logic                   no_overlap;
   } rsp_type;

   typedef struct packed {
      logic query_amino;
      logic both_amino;
      logic same_byte;
      logic last_column;
   } col_class_type;

   function automatic logic is_amino(input logic [7:0] b);
      logic       letter;
      logic [7:0] u;
      logic       hit;
      letter = (b inside {[8'h41:8'h5A], [8'h61:8'h7A]});
      u      = b & 8'hDF;
      case (u)
         "A", "C", "D", "E", "F", "G", "H", "I", "K", "L",
         "M", "N", "P", "Q", "R", "S", "T", "V", "W", "Y": hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return letter & hit;
   endfunction

   function automatic count_type sat_count(input count_type a, input count_type b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s > (COUNT_WIDTH + 1)'(MAX_COLUMNS)) begin
         return COUNT_WIDTH'(MAX_COLUMNS);
      end
      return s[COUNT_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- hdl/psi_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psi_front: column intake
// Accepts alignment columns, classifies the residue pair and queues the
// result for the counting stage in a two-entry queue.
// ----------------------------------------------------------------------------
module psi_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire psi_pkg::req_type    req_data,
   output logic                     col_valid,
   input  wire                      col_ready,
   output psi_pkg::col_class_type   col_data
);

   psi_pkg::col_class_type                   entry_ff [psi_pkg::QUEUE_DEPTH];
   logic [psi_pkg::QUEUE_PTR_WIDTH-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [psi_pkg::QUEUE_PTR_WIDTH-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [psi_pkg::QUEUE_CNT_WIDTH-1:0]      count_ff, count_in;
   psi_pkg::col_class_type                   class_in;
   logic                                     push, pop;

   always_comb begin
      class_in.query_amino = psi_pkg::is_amino(req_data.residue_query);
      class_in.both_amino  = class_in.query_amino &
                             psi_pkg::is_amino(req_data.residue_reference);
      class_in.same_byte   = (req_data.residue_query == req_data.residue_reference);
      class_in.last_column = req_data.last_column;
   end

   assign req_ready = (count_ff != psi_pkg::QUEUE_CNT_WIDTH'(psi_pkg::QUEUE_DEPTH));
   assign col_valid = (count_ff != '0);
   assign col_data  = entry_ff[rd_ptr_ff];
   assign push      = req_valid & req_ready;
   assign pop       = col_valid & col_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= class_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/psi_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psi_back: region counting and result
// Keeps committed and pending counts per alignment, closes the alignment on
// the last column and computes the keep decision in the output stage.
// ----------------------------------------------------------------------------
module psi_back (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [psi_pkg::IDENTITY_WIDTH-1:0]  min_identity,
   input  wire                                 col_valid,
   output logic                                col_ready,
   input  wire  psi_pkg::col_class_type        col_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output psi_pkg::rsp_type                    rsp_data
);

   logic                   region_started_ff, region_started_in;
   psi_pkg::count_type     committed_identical_ff, committed_identical_in;
   psi_pkg::count_type     committed_aligned_ff, committed_aligned_in;
   psi_pkg::count_type     pending_identical_ff, pending_identical_in;
   psi_pkg::count_type     pending_aligned_ff, pending_aligned_in;

   logic                   fin_valid_ff, fin_valid_in;
   psi_pkg::count_type     fin_identical_ff;
   psi_pkg::count_type     fin_aligned_ff;
   logic                   fin_none_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   psi_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   logic                   out_ready, fin_ready, pop, close;
   logic                   started;
   psi_pkg::count_type     pend_i, pend_a, comm_i, comm_a;
   logic [psi_pkg::PRODUCT_WIDTH-1:0] product, scaled;

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign fin_ready = !fin_valid_ff || out_ready;
   assign col_ready = !col_data.last_column || fin_ready;
   assign pop       = col_valid & col_ready;
   assign close     = pop & col_data.last_column;

   always_comb begin
      started = region_started_ff | col_data.both_amino;
      pend_i  = pending_identical_ff;
      pend_a  = pending_aligned_ff;
      comm_i  = committed_identical_ff;
      comm_a  = committed_aligned_ff;
      if (started && col_data.query_amino) begin
         pend_a = psi_pkg::sat_count(pending_aligned_ff, psi_pkg::COUNT_WIDTH'(1));
         if (col_data.same_byte) begin
            pend_i = psi_pkg::sat_count(pending_identical_ff, psi_pkg::COUNT_WIDTH'(1));
         end
      end
      if (col_data.both_amino) begin
         comm_a = psi_pkg::sat_count(committed_aligned_ff, pend_a);
         comm_i = psi_pkg::sat_count(committed_identical_ff, pend_i);
         pend_a = '0;
         pend_i = '0;
      end

      region_started_in      = region_started_ff;
      committed_identical_in = committed_identical_ff;
      committed_aligned_in   = committed_aligned_ff;
      pending_identical_in   = pending_identical_ff;
      pending_aligned_in     = pending_aligned_ff;
      if (close) begin
         region_started_in      = 1'b0;
         committed_identical_in = '0;
         committed_aligned_in   = '0;
         pending_identical_in   = '0;
         pending_aligned_in     = '0;
      end else if (pop) begin
         region_started_in      = started;
         committed_identical_in = comm_i;
         committed_aligned_in   = comm_a;
         pending_identical_in   = pend_i;
         pending_aligned_in     = pend_a;
      end

      fin_valid_in = close ? 1'b1 : (out_ready ? 1'b0 : fin_valid_ff);
   end

   always_comb begin
      product = psi_pkg::PRODUCT_WIDTH'(min_identity) * psi_pkg::PRODUCT_WIDTH'(fin_aligned_ff);
      scaled  = psi_pkg::PRODUCT_WIDTH'({fin_identical_ff,
                                          {psi_pkg::FRACTION_BITS{1'b0}}});
      rsp_data_in.identical_count = fin_none_ff ? '0 : fin_identical_ff;
      rsp_data_in.aligned_count   = fin_none_ff ? '0 : fin_aligned_ff;
      rsp_data_in.keep_flag       = !fin_none_ff && (scaled >= product);
      rsp_data_in.no_overlap      = fin_none_ff;
      rsp_valid_in = out_ready ? fin_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_started_ff      <= 1'b0;
         committed_identical_ff <= '0;
         committed_aligned_ff   <= '0;
         pending_identical_ff   <= '0;
         pending_aligned_ff     <= '0;
         fin_valid_ff           <= 1'b0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         region_started_ff      <= region_started_in;
         committed_identical_ff <= committed_identical_in;
         committed_aligned_ff   <= committed_aligned_in;
         pending_identical_ff   <= pending_identical_in;
         pending_aligned_ff     <= pending_aligned_in;
         fin_valid_ff           <= fin_valid_in;
         rsp_valid_ff           <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (close) begin
         fin_identical_ff <= comm_i;
         fin_aligned_ff   <= comm_a;
         fin_none_ff      <= !started;
      end
      if (out_ready && fin_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_overlap_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.no_overlap) |->
         (rsp_data_ff.identical_count == '0 && rsp_data_ff.aligned_count == '0 &&
          !rsp_data_ff.keep_flag))
      else $error("no-overlap result carries counts or keep");

   a_identical_le_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.identical_count <= rsp_data_ff.aligned_count))
      else $error("identical count exceeds aligned count");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      (committed_aligned_ff <= psi_pkg::COUNT_WIDTH'(psi_pkg::MAX_COLUMNS) &&
       pending_aligned_ff <= psi_pkg::COUNT_WIDTH'(psi_pkg::MAX_COLUMNS)))
      else $error("count above saturation limit");

   a_clear_after_close: assert property (@(posedge clock) disable iff (reset)
      close |=> (!region_started_ff && committed_aligned_ff == '0 &&
                 pending_aligned_ff == '0 && fin_valid_ff))
      else $error("state not cleared after last column");

endmodule
`default_nettype wire

// ----- hdl/pairwise_sequence_identity_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pairwise_sequence_identity_top: percent identity of an aligned pair
// Counts aligned and identical columns over the overlap region of a query
// and reference alignment and reports them with a keep decision.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  psi_pkg::req_type, one column
//   rsp      out        rsp_valid/rsp_ready  psi_pkg::rsp_type, one per alignment
//   csr      in         csr_wr_en            csr_wr_data, min_identity
//
// One column is taken per cycle while the queue has room; the counting stage
// updates its counters once per column.
// After the last column is accepted, the result passes through the queue,
// the finish stage and then the output register with the keep multiply.
// Reset clears the committed and pending counts and sets min_identity to zero.
// A two-entry queue lets intake continue while the result output is stalled.
// ----------------------------------------------------------------------------
module pairwise_sequence_identity_top (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  psi_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output psi_pkg::rsp_type                    rsp_data,
   input  wire                                 csr_wr_en,
   input  wire  [psi_pkg::IDENTITY_WIDTH-1:0]  csr_wr_data
);

   logic [psi_pkg::IDENTITY_WIDTH-1:0] min_identity_ff, min_identity_in;
   logic                               col_valid;
   logic                               col_ready;
   psi_pkg::col_class_type             col_data;

   assign min_identity_in = csr_wr_en ? csr_wr_data : min_identity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_identity_ff <= '0;
      end else begin
         min_identity_ff <= min_identity_in;
      end
   end

   psi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .col_valid (col_valid),
      .col_ready (col_ready),
      .col_data  (col_data)
   );

   psi_back u_back (
      .clock        (clock),
      .reset        (reset),
      .min_identity (min_identity_ff),
      .col_valid    (col_valid),
      .col_ready    (col_ready),
      .col_data     (col_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule
`default_nettype wire
